// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pair force check failed");

// An implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    `CHK_PROP(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ----- rtl/core/sph_pf_pkg.sv -----
// ----------------------------------------------------------------------------
// sph_pf_pkg
// Types and constants of the SPH pair force block.
// ----------------------------------------------------------------------------
package sph_pf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // Stages of the pipeline that do not depend on the fraction width.
    localparam int PIPE_BASE     = 49;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIM_SCALE   = 3'd0,
        REG_RADIUS      = 3'd1,
        REG_MASS        = 3'd2,
        REG_VISCOSITY   = 3'd3,
        REG_SPIKY       = 3'd4,
        REG_LAPLACIAN   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] dvel_x;
        logic signed [31:0] dvel_y;
        logic signed [31:0] dvel_z;
        logic signed [31:0] pressure_self;
        logic signed [31:0] pressure_other;
        logic        [30:0] inv_density_self;
        logic        [30:0] inv_density_other;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               coincident;
    } t_out;

endpackage

// ----- rtl/core/sph_pair_force.sv -----
// ----------------------------------------------------------------------------
// sph_pair_force
// Pressure and viscosity force of one neighbor on one particle, Q16.16.
// ----------------------------------------------------------------------------
// A pair transfer is taken at a clock edge where start is high and busy is
// low. Busy is high only while reset is asserted, so a new pair can enter in
// every cycle. The result, in Q16.16 at the default FRAC_BITS, appears on
// o_out for exactly one cycle, marked by o_strobe. Throughput is one pair
// per cycle. The latency is set by the square root, which resolves one
// result bit per stage over 32 stages, and by the three parallel dividers
// for the unit direction, which resolve one quotient bit per stage over
// FRAC_BITS + 1 stages. The scalar kernel chains follow as ten multiply and
// round stages. The receiver cannot stall, so the pipeline never holds;
// valid bits travel with the data. Reset clears the valid bits and sets each
// config register to 1.0. Registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_wdata; the user must write them only while no pair is in flight,
// which the block does not enforce. Writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module sph_pair_force #(
    parameter int FRAC_BITS = sph_pf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  sph_pf_pkg::t_in                    i_in,
    output logic                               o_strobe,
    output sph_pf_pkg::t_out                   o_out,
    input  logic                               i_cfg_we,
    input  logic [sph_pf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sph_pf_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int NST    = sph_pf_pkg::PIPE_BASE + FRAC_BITS;
    localparam int S_IN   = 0;
    localparam int S_MUL  = 1;
    localparam int S_RND  = 2;
    localparam int S_SQ   = 3;
    localparam int S_SUM  = 4;
    localparam int S_RT0  = 5;
    localparam int S_C    = S_RT0 + 32;
    localparam int S_DV0  = S_C + 1;
    localparam int S_M0   = S_DV0 + FRAC_BITS + 1;

    localparam logic        [30:0] ONE_U = 31'(1) << FRAC_BITS;
    localparam logic signed [31:0] ONE_S = 32'(1) << FRAC_BITS;
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct {
        logic signed [31:0]        rel [3];
        logic signed [31:0]        dv [3];
        logic signed [31:0]        pself;
        logic signed [31:0]        pother;
        logic        [30:0]        invs;
        logic        [30:0]        invo;
        logic                      coin;
        logic signed [63:0]        p1 [3];
        logic signed [63:0]        p2 [3];
        logic signed [31:0]        s [3];
        logic        [63:0]        sqa [3];
        logic        [63:0]        sq;
        logic        [34:0]        rem;
        logic        [31:0]        root;
        logic signed [32:0]        negph;
        logic signed [31:0]        c;
        logic        [31:0]        mag [3];
        logic                      neg [3];
        logic        [32:0]        drem [3];
        logic        [FRAC_BITS:0] quo [3];
        logic signed [FRAC_BITS+1:0] dir [3];
        logic signed [63:0]        pa;
        logic signed [63:0]        pb;
        logic signed [63:0]        pc;
        logic signed [31:0]        c2;
        logic signed [31:0]        pk;
        logic signed [31:0]        vk;
        logic signed [31:0]        g;
        logic signed [31:0]        f [3];
        logic signed [31:0]        frc [3];
    } t_ctx;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fx_rnd(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + HALF) >>> FRAC_BITS;
        return sat32(r);
    endfunction

    logic        [30:0] r_scale;
    logic        [30:0] r_radius;
    logic        [30:0] r_mass;
    logic        [30:0] r_visc;
    logic signed [31:0] r_spiky;
    logic signed [31:0] r_lap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= ONE_U;
            r_radius <= ONE_U;
            r_mass   <= ONE_U;
            r_visc   <= ONE_U;
            r_spiky  <= ONE_S;
            r_lap    <= ONE_S;
        end else if (i_cfg_we) begin
            unique case (sph_pf_pkg::t_cfg_idx'(i_cfg_idx))
                sph_pf_pkg::REG_SIM_SCALE: r_scale  <= i_cfg_wdata[30:0];
                sph_pf_pkg::REG_RADIUS:    r_radius <= i_cfg_wdata[30:0];
                sph_pf_pkg::REG_MASS:      r_mass   <= i_cfg_wdata[30:0];
                sph_pf_pkg::REG_VISCOSITY: r_visc   <= i_cfg_wdata[30:0];
                sph_pf_pkg::REG_SPIKY:     r_spiky  <= $signed(i_cfg_wdata);
                sph_pf_pkg::REG_LAPLACIAN: r_lap    <= $signed(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    assign busy = !i_rst_n;

    t_ctx             r_st [NST];
    t_ctx             n_st [NST];
    logic [NST-1:0]   r_vld;

    for (genvar g = 0; g < NST; g++) begin : g_stage
        if (g == S_IN) begin : g_in
            always_comb begin
                n_st[g]        = '{default: '0};
                n_st[g].rel[0] = i_in.rel_x;
                n_st[g].rel[1] = i_in.rel_y;
                n_st[g].rel[2] = i_in.rel_z;
                n_st[g].dv[0]  = i_in.dvel_x;
                n_st[g].dv[1]  = i_in.dvel_y;
                n_st[g].dv[2]  = i_in.dvel_z;
                n_st[g].pself  = i_in.pressure_self;
                n_st[g].pother = i_in.pressure_other;
                n_st[g].invs   = i_in.inv_density_self;
                n_st[g].invo   = i_in.inv_density_other;
            end
        end else if (g == S_MUL) begin : g_mul
            always_comb begin
                logic signed [33:0] psum;
                logic signed [33:0] ph;
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    n_st[g].p1[a] = 64'(r_st[g-1].rel[a]) * 64'($signed({1'b0, r_scale}));
                end
                psum = 34'(r_st[g-1].pself) + 34'(r_st[g-1].pother) + 34'sd1;
                ph   = psum >>> 1;
                n_st[g].negph = 33'(-ph);
                n_st[g].coin  = (r_st[g-1].rel[0] == 0) && (r_st[g-1].rel[1] == 0)
                                && (r_st[g-1].rel[2] == 0);
            end
        end else if (g == S_RND) begin : g_rnd
            always_comb begin
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    n_st[g].s[a] = fx_rnd(r_st[g-1].p1[a]);
                end
            end
        end else if (g == S_SQ) begin : g_sq
            always_comb begin
                logic [31:0] m;
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    m = r_st[g-1].s[a][31] ? 32'(-r_st[g-1].s[a]) : 32'(r_st[g-1].s[a]);
                    n_st[g].sqa[a] = 64'(m) * 64'(m);
                end
            end
        end else if (g == S_SUM) begin : g_sum
            always_comb begin
                n_st[g]      = r_st[g-1];
                n_st[g].sq   = r_st[g-1].sqa[0] + r_st[g-1].sqa[1] + r_st[g-1].sqa[2];
                n_st[g].rem  = '0;
                n_st[g].root = '0;
            end
        end else if (g >= S_RT0 && g < S_C) begin : g_rt
            localparam int BI = 31 - (g - S_RT0);
            always_comb begin
                logic [34:0] rs;
                logic [34:0] trial;
                n_st[g] = r_st[g-1];
                rs      = {r_st[g-1].rem[32:0], r_st[g-1].sq[2*BI+1 -: 2]};
                trial   = {1'b0, r_st[g-1].root, 2'b01};
                if (rs >= trial) begin
                    n_st[g].rem  = rs - trial;
                    n_st[g].root = {r_st[g-1].root[30:0], 1'b1};
                end else begin
                    n_st[g].rem  = rs;
                    n_st[g].root = {r_st[g-1].root[30:0], 1'b0};
                end
            end
        end else if (g == S_C) begin : g_c
            always_comb begin
                logic signed [33:0] diff;
                n_st[g] = r_st[g-1];
                diff    = $signed({3'b000, r_radius}) - $signed({2'b00, r_st[g-1].root});
                n_st[g].c = sat32(64'(diff));
                for (int a = 0; a < 3; a++) begin
                    n_st[g].neg[a]  = r_st[g-1].s[a][31];
                    n_st[g].mag[a]  = r_st[g-1].s[a][31] ? 32'(-r_st[g-1].s[a])
                                                         : 32'(r_st[g-1].s[a]);
                    n_st[g].drem[a] = 33'(n_st[g].mag[a] >> 1);
                    n_st[g].quo[a]  = '0;
                end
            end
        end else if (g >= S_DV0 && g < S_M0) begin : g_dv
            always_comb begin
                logic [32:0] t;
                logic        b;
                logic        q;
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    b = (g == S_DV0) ? r_st[g-1].mag[a][0] : 1'b0;
                    t = {r_st[g-1].drem[a][31:0], b};
                    q = (t >= {1'b0, r_st[g-1].root});
                    n_st[g].drem[a] = q ? t - {1'b0, r_st[g-1].root} : t;
                    n_st[g].quo[a]  = {r_st[g-1].quo[a][FRAC_BITS-1:0], q};
                end
            end
        end else if (g == S_M0) begin : g_m0
            always_comb begin
                logic signed [FRAC_BITS+1:0] qs;
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    qs = $signed({1'b0, r_st[g-1].quo[a]});
                    if (r_st[g-1].root == 0) begin
                        n_st[g].dir[a] = '0;
                    end else begin
                        n_st[g].dir[a] = r_st[g-1].neg[a] ? -qs : qs;
                    end
                end
                n_st[g].pa = 64'(r_st[g-1].c) * 64'(r_st[g-1].c);
                n_st[g].pb = 64'(r_lap) * 64'(r_st[g-1].c);
                n_st[g].pc = 64'(r_st[g-1].c) * 64'($signed({1'b0, r_mass}));
            end
        end else if (g == S_M0 + 1) begin : g_m1
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].c2 = fx_rnd(r_st[g-1].pa);
                n_st[g].vk = fx_rnd(r_st[g-1].pb);
                n_st[g].g  = fx_rnd(r_st[g-1].pc);
            end
        end else if (g == S_M0 + 2) begin : g_m2
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].pa = 64'(r_spiky) * 64'(r_st[g-1].c2);
                n_st[g].pb = 64'(r_st[g-1].vk) * 64'(r_st[g-1].c);
                n_st[g].pc = 64'(r_st[g-1].g) * 64'($signed({1'b0, r_st[g-1].invs}));
            end
        end else if (g == S_M0 + 3) begin : g_m3
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].pk = fx_rnd(r_st[g-1].pa);
                n_st[g].vk = fx_rnd(r_st[g-1].pb);
                n_st[g].g  = fx_rnd(r_st[g-1].pc);
            end
        end else if (g == S_M0 + 4) begin : g_m4
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].pa = 64'(r_st[g-1].pk) * 64'(r_st[g-1].negph);
                n_st[g].pb = 64'(r_st[g-1].vk) * 64'($signed({1'b0, r_visc}));
                n_st[g].pc = 64'(r_st[g-1].g) * 64'($signed({1'b0, r_st[g-1].invo}));
            end
        end else if (g == S_M0 + 5) begin : g_m5
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].pk = fx_rnd(r_st[g-1].pa);
                n_st[g].vk = fx_rnd(r_st[g-1].pb);
                n_st[g].g  = fx_rnd(r_st[g-1].pc);
            end
        end else if (g == S_M0 + 6) begin : g_m6
            always_comb begin
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    n_st[g].p1[a] = 64'(r_st[g-1].pk) * 64'(r_st[g-1].dir[a]);
                    n_st[g].p2[a] = 64'(r_st[g-1].vk) * 64'(r_st[g-1].dv[a]);
                end
            end
        end else if (g == S_M0 + 7) begin : g_m7
            always_comb begin
                logic signed [32:0] sum;
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    sum = 33'(fx_rnd(r_st[g-1].p1[a])) + 33'(fx_rnd(r_st[g-1].p2[a]));
                    n_st[g].f[a] = sat32(64'(sum));
                end
            end
        end else if (g == S_M0 + 8) begin : g_m8
            always_comb begin
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    n_st[g].p1[a] = 64'(r_st[g-1].f[a]) * 64'(r_st[g-1].g);
                end
            end
        end else begin : g_m9
            always_comb begin
                n_st[g] = r_st[g-1];
                for (int a = 0; a < 3; a++) begin
                    n_st[g].frc[a] = r_st[g-1].coin ? 32'sd0 : fx_rnd(r_st[g-1].p1[a]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], start && !busy};
        end
    end

    assign o_strobe         = r_vld[NST-1];
    assign o_out.force_x    = r_st[NST-1].frc[0];
    assign o_out.force_y    = r_st[NST-1].frc[1];
    assign o_out.force_z    = r_st[NST-1].frc[2];
    assign o_out.coincident = r_st[NST-1].coin;

endmodule

// ----- rtl/core/sph_pf_chk.sv -----
// ----------------------------------------------------------------------------
// sph_pf_chk
// Port-level checks of the SPH pair force block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sph_pf_chk #(
    parameter int FRAC_BITS = sph_pf_pkg::FRAC_BITS_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input sph_pf_pkg::t_in  i_in,
    input logic             o_strobe,
    input sph_pf_pkg::t_out o_out
);

    localparam int LAT = sph_pf_pkg::PIPE_BASE + FRAC_BITS;

    // Every transfer in gives exactly one result strobe, and no strobe comes without one.
    `CHK_PROP(a_latency, i_clk, i_rst_n, o_strobe == $past(start && !busy, LAT))

    `CHK_IMPL(a_coin_flag, i_clk, i_rst_n, o_strobe, o_out.coincident == $past(i_in.rel_x == 0 && i_in.rel_y == 0 && i_in.rel_z == 0, LAT))

    `CHK_IMPL(a_coin_zero, i_clk, i_rst_n, o_strobe && o_out.coincident, o_out.force_x == 0 && o_out.force_y == 0 && o_out.force_z == 0)

endmodule

bind sph_pair_force sph_pf_chk #(.FRAC_BITS(FRAC_BITS)) u_sph_pf_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);

// ----- test/sph_pair_force_tb.sv -----
// ----------------------------------------------------------------------------
// sph_pair_force_tb
// Self-checking bench for the SPH pair force pipeline. A directed table covers
// the field extremes, coincident and zero-distance pairs, and pairs outside
// the radius. Random pairs follow under several register settings. Every
// result is compared field by field with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module sph_pair_force_tb;
    import sph_pf_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LAT = PIPE_BASE + FRAC;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
    localparam int N_PHASE = 6;
    localparam int ITEMS_PER_PHASE = 280;

    typedef struct {
        t_in  pair;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in i_in = '0;
    logic o_strobe;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    logic [30:0] scale_r, radius_r, mass_r, visc_r;
    logic signed [31:0] spiky_r, lap_r;

    t_out force_due[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_coinc = 0;
    t_row dir_rows[$];

    sph_pair_force i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_strobe(o_strobe), .o_out(o_out), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip32(round_shift(a * b, FRAC));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out pair_force(t_in p);
        longint rel[3], vel[3], sc[3], dir[3], a, dl, c, c2, ph, pk, vk, g, f;
        logic [63:0] sq;
        t_out res;
        rel[0] = longint'(p.rel_x);
        rel[1] = longint'(p.rel_y);
        rel[2] = longint'(p.rel_z);
        vel[0] = longint'(p.dvel_x);
        vel[1] = longint'(p.dvel_y);
        vel[2] = longint'(p.dvel_z);
        res = '0;
        if (rel[0] == 0 && rel[1] == 0 && rel[2] == 0) begin
            res.coincident = 1'b1;
            return res;
        end
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            sc[i] = qmul(rel[i], longint'({1'b0, scale_r}));
            a = sc[i] < 0 ? -sc[i] : sc[i];
            sq = sq + 64'(a) * 64'(a);
        end
        dl = longint'(int_sqrt(sq));
        for (int i = 0; i < 3; i++)
            dir[i] = (dl == 0) ? 0 : (sc[i] * (longint'(1) <<< FRAC)) / dl;
        c = clip32(longint'({1'b0, radius_r}) - dl);
        c2 = qmul(c, c);
        ph = round_shift(longint'(p.pressure_self) + longint'(p.pressure_other), 1);
        pk = qmul(longint'(spiky_r), c2);
        pk = qmul(pk, -ph);
        vk = qmul(longint'(lap_r), c);
        vk = qmul(vk, c);
        vk = qmul(vk, longint'({1'b0, visc_r}));
        g = qmul(c, longint'({1'b0, mass_r}));
        g = qmul(g, longint'({1'b0, p.inv_density_self}));
        g = qmul(g, longint'({1'b0, p.inv_density_other}));
        f = qmul(clip32(qmul(pk, dir[0]) + qmul(vk, vel[0])), g);
        res.force_x = f[31:0];
        f = qmul(clip32(qmul(pk, dir[1]) + qmul(vk, vel[1])), g);
        res.force_y = f[31:0];
        f = qmul(clip32(qmul(pk, dir[2]) + qmul(vk, vel[2])), g);
        res.force_z = f[31:0];
        return res;
    endfunction

    // Predictions are made at the accepting edge and results checked at the
    // edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && start && !busy) force_due.push_back(pair_force(i_in));
        if (i_rst_n && o_strobe) begin
            if (force_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                want = force_due.pop_front();
                n_checked++;
                if (o_out.coincident) n_coinc++;
                if (o_out.force_x !== want.force_x || o_out.force_y !== want.force_y ||
                    o_out.force_z !== want.force_z || o_out.coincident !== want.coincident)
                begin
                    $display("%0t: mismatch exp x=%h y=%h z=%h c=%b act x=%h y=%h z=%h c=%b",
                             $time, want.force_x, want.force_y, want.force_z,
                             want.coincident, o_out.force_x, o_out.force_y,
                             o_out.force_z, o_out.coincident);
                    errors++;
                end
            end
        end
    end

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        case (idx)
            REG_SIM_SCALE: scale_r = v[30:0];
            REG_RADIUS:    radius_r = v[30:0];
            REG_MASS:      mass_r = v[30:0];
            REG_VISCOSITY: visc_r = v[30:0];
            REG_SPIKY:     spiky_r = v;
            REG_LAPLACIAN: lap_r = v;
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (force_due.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    task automatic send(t_in p, int gap);
        i_in <= p;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
        endcase
    endfunction

    function automatic t_in rand_pair();
        t_in p;
        int mode;
        mode = ($urandom_range(0, 9) == 0) ? 0 : 2;
        p.rel_x = rand_word(($urandom_range(0, 19) == 0) ? 1 : mode);
        p.rel_y = rand_word(mode);
        p.rel_z = rand_word(mode);
        if ($urandom_range(0, 30) == 0) begin
            p.rel_x = '0;
            p.rel_y = '0;
            p.rel_z = '0;
        end
        p.dvel_x = rand_word(mode);
        p.dvel_y = rand_word(($urandom_range(0, 19) == 0) ? 1 : mode);
        p.dvel_z = rand_word(mode);
        p.pressure_self = rand_word(mode);
        p.pressure_other = rand_word(($urandom_range(0, 19) == 0) ? 1 : mode);
        p.inv_density_self = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h20000));
        p.inv_density_other = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h20000));
        return p;
    endfunction

    function automatic t_row row(logic [31:0] rx, ry, rz, vx, vy, vz, ps, po,
                                 logic [30:0] ids, ido);
        t_row r;
        r.pair = '{rx, ry, rz, vx, vy, vz, ps, po, ids, ido};
        r.typed = (rx == 0 && ry == 0 && rz == 0);
        r.want = '0;
        if (r.typed) r.want.coincident = 1'b1;
        return r;
    endfunction

    initial begin
        scale_r = 31'h10000;
        radius_r = 31'h10000;
        mass_r = 31'h10000;
        visc_r = 31'h10000;
        spiky_r = 32'sh10000;
        lap_r = 32'sh10000;
        dir_rows.push_back(row(0, 0, 0, 32'h7fffffff, 32'h80000000, 5, 1, 2, 31'h7fffffff, 1));
        dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0, 0));
        dir_rows.push_back(row(32'h8000, 0, 0, 32'h10000, 0, 0, 32'h20000, 32'h10000,
                               31'h10000, 31'h10000));
        dir_rows.push_back(row(0, 32'hffff8000, 32'h4000, 0, 32'h10000, 32'hffff0000,
                               32'h30000, 32'h10000, 31'h8000, 31'h20000));
        dir_rows.push_back(row(32'h7fffffff, 0, 0, 32'h10000, 32'h10000, 32'h10000,
                               32'h10000, 32'h10000, 31'h10000, 31'h10000));
        dir_rows.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               31'h7fffffff, 31'h7fffffff));
        dir_rows.push_back(row(32'h30000, 32'h30000, 0, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 31'h10000, 31'h10000));
        dir_rows.push_back(row(1, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 31'h10000, 31'h10000));
        dir_rows.push_back(row(0, 0, 32'hffffffff, 0, 0, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 31'h7fffffff, 31'h7fffffff));
        dir_rows.push_back(row(32'h1000, 32'h2000, 32'h3000, 32'h12345, 32'hfff00000,
                               32'h777, 32'h40000, 32'hfffc0000, 0, 31'h10000));
        dir_rows.push_back(row(32'hfffff000, 32'h800, 32'h10000, 32'h55555555, 32'haaaaaaaa,
                               32'h1, 32'h12345678, 32'hedcba987, 31'h2aaaaaaa, 31'h55555555));
        dir_rows.push_back(row(32'h20000, 32'h20000, 32'h20000, 32'h10000, 32'h10000,
                               32'h10000, 32'h10000, 32'h10000, 31'h10000, 31'h10000));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].typed && pair_force(dir_rows[k].pair) != dir_rows[k].want) begin
                $display("%0t: coincident row %0d not zero in prediction", $time, k);
                errors++;
            end
            send(dir_rows[k].pair, (k % 3 == 0) ? $urandom_range(0, 4) : 0);
        end
        drain();

        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                1: begin
                    set_reg(REG_SIM_SCALE, 32'h10000);
                    set_reg(REG_RADIUS, $urandom_range(32'h8000, 32'h40000));
                    set_reg(REG_MASS, $urandom_range(0, 32'h20000));
                    set_reg(REG_VISCOSITY, $urandom_range(0, 32'h20000));
                    set_reg(REG_SPIKY, 32'($urandom_range(0, 32'h40000)) - 32'h20000);
                    set_reg(REG_LAPLACIAN, 32'($urandom_range(0, 32'h40000)) - 32'h20000);
                    set_reg(IDX_UNUSED_LO, 32'h0);
                    set_reg(IDX_UNUSED_HI, 32'hffffffff);
                end
                2: begin
                    set_reg(REG_SIM_SCALE, 32'hffffffff);
                    set_reg(REG_RADIUS, 32'hffffffff);
                    set_reg(REG_MASS, 32'hffffffff);
                    set_reg(REG_VISCOSITY, 32'hffffffff);
                    set_reg(REG_SPIKY, 32'h7fffffff);
                    set_reg(REG_LAPLACIAN, 32'h80000000);
                end
                3: begin
                    set_reg(REG_SIM_SCALE, 0);
                    set_reg(REG_RADIUS, 0);
                    set_reg(REG_MASS, 0);
                    set_reg(REG_VISCOSITY, 0);
                    set_reg(REG_SPIKY, 32'h80000000);
                    set_reg(REG_LAPLACIAN, 32'h7fffffff);
                end
                4: begin
                    set_reg(REG_SIM_SCALE, 1);
                    set_reg(REG_RADIUS, 32'h10000);
                    set_reg(REG_MASS, 32'h10000);
                    set_reg(REG_VISCOSITY, 32'h8000);
                    set_reg(REG_SPIKY, 32'hffff0000);
                    set_reg(REG_LAPLACIAN, 32'h18000);
                end
                5: begin
                    set_reg(REG_SIM_SCALE, $urandom);
                    set_reg(REG_RADIUS, $urandom);
                    set_reg(REG_MASS, $urandom);
                    set_reg(REG_VISCOSITY, $urandom);
                    set_reg(REG_SPIKY, $urandom);
                    set_reg(REG_LAPLACIAN, $urandom);
                end
                default: ;
            endcase
            i_cfg_we <= 1'b0;
            begin
                int left, burst;
                left = ITEMS_PER_PHASE;
                while (left > 0) begin
                    burst = $urandom_range(1, 40);
                    if (burst > left) burst = left;
                    for (int j = 0; j < burst; j++)
                        send(rand_pair(), (j == burst - 1) ? $urandom_range(1, 12) : 0);
                    left -= burst;
                    if (left > 0 && left < 60 && ph == 1) begin
                        start <= 1'b0;
                        while (force_due.size() != 0) @(posedge i_clk);
                    end
                end
            end
            drain();
        end

        $display("Sent %0d pairs over %0d register settings; %0d results checked, %0d coincident.",
                 n_sent, N_PHASE, n_checked, n_coinc);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sph_pf_pkg.sv
rtl/core/sph_pair_force.sv
rtl/core/sph_pf_chk.sv
test/sph_pair_force_tb.sv
